### rtl/tds_pkg.sv
// Shared types and constants for the trimmed depth statistic block.
// Used by trimmed_depth_statistic_top; no dependencies.
package tds_pkg;

   localparam int DEPTH_W   = 16;
   localparam int OUT_W     = 20;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 13;
   localparam int MODE_W    = 2;
   localparam int PCT_W     = 11;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;
   localparam int RATIO_W   = 9;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_MIN_DEPTH   = 3'd0;
   localparam csr_idx_type CSR_MAX_DEPTH   = 3'd1;
   localparam csr_idx_type CSR_REDUCE_MODE = 3'd2;
   localparam csr_idx_type CSR_PERCENTILE  = 3'd3;
   localparam csr_idx_type CSR_TRIM_RATIO  = 3'd4;

   typedef logic [MODE_W-1:0] mode_type;
   localparam mode_type MODE_MEAN   = 2'd0;
   localparam mode_type MODE_MEDIAN = 2'd1;
   localparam mode_type MODE_PCT    = 2'd2;
   localparam mode_type MODE_SPARE  = 2'd3;  // decoded as median

   typedef logic [STATUS_W-1:0] status_type;
   localparam status_type STATUS_OK       = 2'd0;
   localparam status_type STATUS_EMPTY    = 2'd1;
   localparam status_type STATUS_OVERFLOW = 2'd2;

   localparam logic [RATIO_W-1:0] TRIM_CAP = 9'd501;
   localparam logic [PCT_W-1:0]   PCT_MAX  = 11'd1024;

endpackage

### rtl/tds_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Standalone; used by trimmed_depth_statistic_top for the mean.
module tds_div #(
   parameter int DW = 33,
   parameter int VW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);
   localparam int CNT_W = $clog2(DW + 1);

   logic             run_ff, run_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VW-1:0]    rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW:0]      trial;
   logic             qbit;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      qbit    = trial >= {1'b0, divisor};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         rem_in = '0;
         quo_in = dividend;
      end else if (run_ff) begin
         rem_in = qbit ? VW'(trial - {1'b0, divisor}) : trial[VW-1:0];
         quo_in = {quo_ff[DW-2:0], qbit};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(DW - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

### rtl/trimmed_depth_statistic_top.sv
// Trimmed depth statistic: collects masked depth samples of one area, then
// reduces them to a trimmed mean, median or percentile. Uses tds_pkg, tds_div.
//
// Usage:
//  - req_ channel: one pixel per transaction (depth_mm, mask_set, last_pixel).
//    Pixels are taken one per cycle while the block is collecting.
//  - A pixel with last_pixel closes the area. The block then stalls req_ and
//    runs order-statistic passes over the sample memory; one rsp_ transaction
//    follows with depth_out, status and sample_count.
//  - Reduction with n stored samples: 16 bitwise rank-search passes, each
//    reading all n samples (both ranks searched together, one memory read per
//    cycle), then S_FINAL (median) or S_FINAL and S_PCT (percentile). Mean
//    without trimming skips the passes and goes to the divider. Mean with
//    trimming adds a summing pass and S_EXTRA before the divider.
//    An empty or overflowed area goes from S_PREP straight to S_EMIT.
//  - Collection of the next area starts once the result sits in the output
//    register; a stalled rsp_ holds it while new pixels are already taken.
//  - csr_ port: write-only, taken whenever csr_we is high; write only while
//    idle. Reset (synchronous) restores register defaults, clears the counters
//    and the output valid. Sample memory content is not cleared.
module trimmed_depth_statistic_top #(
   parameter int MAX_SAMPLES = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tds_pkg::DEPTH_W-1:0]   req_depth_mm,
   input  logic                          req_mask_set,
   input  logic                          req_last_pixel,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tds_pkg::OUT_W-1:0]     rsp_depth_out,
   output logic [tds_pkg::STATUS_W-1:0]  rsp_status,
   output logic [tds_pkg::COUNT_W-1:0]   rsp_sample_count,
   input  logic                          csr_we,
   input  logic [tds_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [tds_pkg::CSR_DAT_W-1:0] csr_wdata
);
   localparam int DW_ = tds_pkg::DEPTH_W;
   localparam int CW  = $clog2(MAX_SAMPLES + 1);
   localparam int AW  = $clog2(MAX_SAMPLES);
   localparam int SW  = DW_ + CW;
   localparam int VW  = SW + 4;
   localparam int PW  = CW + tds_pkg::RATIO_W;
   localparam int QW  = CW + tds_pkg::PCT_W;
   localparam int OW  = tds_pkg::OUT_W;

   typedef enum logic [3:0] {
      S_COLLECT, S_PREP, S_TRIM, S_RANK, S_RANK2, S_PASS, S_SEL_END,
      S_EXTRA, S_MEAN, S_DIV_GO, S_DIV_WAIT, S_FINAL, S_PCT, S_EMIT
   } state_type;

   // configuration
   logic [DW_-1:0]              min_depth_ff, max_depth_ff;
   tds_pkg::mode_type           mode_ff;
   logic [tds_pkg::PCT_W-1:0]   pct_ff, ratio_ff;

   state_type                   state_ff, state_in;
   logic [CW-1:0]               count_ff, count_in;
   logic [SW-1:0]               sum_ff, sum_in;
   logic                        ovf_ff, ovf_in;

   logic [PW-1:0]               prod_ff, prod_in;
   logic [CW-1:0]               cut_ff, cut_in;
   logic [CW-1:0]               m_ff, m_in;
   logic [QW-1:0]               q_ff, q_in;
   logic [9:0]                  frac_ff, frac_in;
   logic [CW-1:0]               ra_ff, ra_in, rb_ff, rb_in;
   logic [DW_-1:0]              va_ff, va_in, vb_ff, vb_in;
   logic [3:0]                  bit_ff, bit_in;
   logic                        sum_pass_ff, sum_pass_in;

   logic [CW-1:0]               rd_cnt_ff, rd_cnt_in;
   logic                        dv_ff, dv_in, dl_ff, dl_in;
   logic [CW-1:0]               cnt_a_ff, cnt_a_in, cnt_b_ff, cnt_b_in;
   logic [SW-1:0]               lo_sum_ff, lo_sum_in, hi_sum_ff, hi_sum_in;
   logic [SW-1:0]               tsum_ff, tsum_in;
   logic [25:0]                 pmul_ff, pmul_in;

   logic [OW-1:0]               res_ff, res_in;
   tds_pkg::status_type         rstat_ff, rstat_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [OW-1:0]               rsp_depth_ff, rsp_depth_in;
   tds_pkg::status_type         rsp_status_ff, rsp_status_in;
   logic [tds_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic [DW_-1:0]              mem [MAX_SAMPLES];
   logic [DW_-1:0]              mem_q_ff;
   logic                        wr_en;
   logic [AW-1:0]               rd_addr;

   logic                        div_start, div_done;
   logic [VW-1:0]               div_dividend, div_quot;

   logic                        accept, keep, issue;
   logic [tds_pkg::RATIO_W-1:0] ratio_c;
   logic [tds_pkg::PCT_W-1:0]   pct_c;
   logic [CW-1:0]               cut_c, lo_c;
   logic                        trim_ok;
   logic [DW_-1:0]              one_hot, low_mask;

   assign accept  = req_valid & ~req_stall;
   assign keep    = req_mask_set && (req_depth_mm != '0) &&
                    (req_depth_mm >= min_depth_ff) && (req_depth_mm <= max_depth_ff);
   assign wr_en   = accept && keep && (count_ff < CW'(MAX_SAMPLES));
   assign rd_addr = rd_cnt_ff[AW-1:0];
   assign issue   = (state_ff == S_PASS) && (rd_cnt_ff != count_ff);
   assign ratio_c = (ratio_ff > tds_pkg::PCT_W'(tds_pkg::TRIM_CAP)) ?
                    tds_pkg::TRIM_CAP : ratio_ff[tds_pkg::RATIO_W-1:0];
   assign pct_c   = (pct_ff > tds_pkg::PCT_MAX) ? tds_pkg::PCT_MAX : pct_ff;
   assign cut_c   = CW'(prod_ff[PW-1:10]);
   assign trim_ok = (count_ff >= CW'(3)) && (ratio_ff != '0) && (cut_c != '0) &&
                    ({cut_c, 1'b0} < {1'b0, count_ff});
   assign lo_c    = CW'(q_ff >> 10);
   assign one_hot = DW_'(1) << bit_ff;
   assign low_mask = one_hot - DW_'(1);
   assign div_dividend = {tsum_ff, 4'b0000} + VW'(m_ff >> 1);
   assign div_start = (state_ff == S_DIV_GO);

   tds_div #(.DW(VW), .VW(CW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (m_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      sum_in        = sum_ff;
      ovf_in        = ovf_ff;
      prod_in       = prod_ff;
      cut_in        = cut_ff;
      m_in          = m_ff;
      q_in          = q_ff;
      frac_in       = frac_ff;
      ra_in         = ra_ff;
      rb_in         = rb_ff;
      va_in         = va_ff;
      vb_in         = vb_ff;
      bit_in        = bit_ff;
      sum_pass_in   = sum_pass_ff;
      rd_cnt_in     = rd_cnt_ff;
      dv_in         = issue;
      dl_in         = issue && (rd_cnt_ff + CW'(1) == count_ff);
      cnt_a_in      = cnt_a_ff;
      cnt_b_in      = cnt_b_ff;
      lo_sum_in     = lo_sum_ff;
      hi_sum_in     = hi_sum_ff;
      tsum_in       = tsum_ff;
      pmul_in       = pmul_ff;
      res_in        = res_ff;
      rstat_in      = rstat_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_depth_in  = rsp_depth_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (issue) begin
         rd_cnt_in = rd_cnt_ff + CW'(1);
      end
      case (state_ff)
         S_COLLECT: begin
            if (accept) begin
               if (keep) begin
                  if (count_ff < CW'(MAX_SAMPLES)) begin
                     count_in = count_ff + CW'(1);
                     sum_in   = sum_ff + SW'(req_depth_mm);
                  end else begin
                     ovf_in = 1'b1;
                  end
               end
               if (req_last_pixel) begin
                  state_in = S_PREP;
               end
            end
         end
         S_PREP: begin
            res_in  = '0;
            prod_in = PW'(count_ff) * PW'(ratio_c);
            if (ovf_ff) begin
               rstat_in = tds_pkg::STATUS_OVERFLOW;
               state_in = S_EMIT;
            end else if (count_ff == '0) begin
               rstat_in = tds_pkg::STATUS_EMPTY;
               state_in = S_EMIT;
            end else begin
               rstat_in = tds_pkg::STATUS_OK;
               state_in = S_TRIM;
            end
         end
         S_TRIM: begin
            cut_in   = trim_ok ? cut_c : '0;
            m_in     = trim_ok ? CW'(count_ff - {cut_c[CW-2:0], 1'b0}) : count_ff;
            state_in = S_RANK;
         end
         S_RANK: begin
            q_in     = QW'(pct_c) * QW'(m_ff - CW'(1));
            state_in = S_RANK2;
         end
         S_RANK2: begin
            frac_in = q_ff[9:0];
            case (mode_ff)
               tds_pkg::MODE_MEAN: begin
                  if (cut_ff != '0) begin
                     ra_in = cut_ff - CW'(1);
                     rb_in = count_ff - cut_ff;
                  end else begin
                     ra_in = '0;
                     rb_in = count_ff - CW'(1);
                  end
               end
               tds_pkg::MODE_PCT: begin
                  ra_in = cut_ff + lo_c;
                  rb_in = cut_ff + lo_c + CW'(q_ff[9:0] != '0);
               end
               default: begin
                  ra_in = cut_ff + CW'((m_ff - CW'(1)) >> 1);
                  rb_in = cut_ff + CW'(m_ff >> 1);
               end
            endcase
            va_in       = '0;
            vb_in       = '0;
            bit_in      = 4'd15;
            sum_pass_in = 1'b0;
            rd_cnt_in   = '0;
            cnt_a_in    = '0;
            cnt_b_in    = '0;
            state_in    = (mode_ff == tds_pkg::MODE_MEAN && cut_ff == '0) ?
                          S_MEAN : S_PASS;
         end
         S_PASS: begin
            if (dv_ff) begin
               if (sum_pass_ff) begin
                  if (mem_q_ff < va_ff) begin
                     cnt_a_in  = cnt_a_ff + CW'(1);
                     lo_sum_in = lo_sum_ff + SW'(mem_q_ff);
                  end
                  if (mem_q_ff > vb_ff) begin
                     cnt_b_in  = cnt_b_ff + CW'(1);
                     hi_sum_in = hi_sum_ff + SW'(mem_q_ff);
                  end
               end else begin
                  if (mem_q_ff <= (va_ff | low_mask)) cnt_a_in = cnt_a_ff + CW'(1);
                  if (mem_q_ff <= (vb_ff | low_mask)) cnt_b_in = cnt_b_ff + CW'(1);
               end
               if (dl_ff) begin
                  state_in = sum_pass_ff ? S_EXTRA : S_SEL_END;
               end
            end
         end
         S_SEL_END: begin
            if (cnt_a_ff <= ra_ff) va_in = va_ff | one_hot;
            if (cnt_b_ff <= rb_ff) vb_in = vb_ff | one_hot;
            rd_cnt_in = '0;
            cnt_a_in  = '0;
            cnt_b_in  = '0;
            lo_sum_in = '0;
            hi_sum_in = '0;
            if (bit_ff != 4'd0) begin
               bit_in   = bit_ff - 4'd1;
               state_in = S_PASS;
            end else if (mode_ff == tds_pkg::MODE_MEAN) begin
               sum_pass_in = 1'b1;
               state_in    = S_PASS;
            end else begin
               state_in = S_FINAL;
            end
         end
         S_EXTRA: begin
            // fill the cut with copies of the boundary values
            lo_sum_in = lo_sum_ff + SW'(cut_ff - cnt_a_ff) * SW'(va_ff);
            hi_sum_in = hi_sum_ff + SW'(cut_ff - cnt_b_ff) * SW'(vb_ff);
            state_in  = S_MEAN;
         end
         S_MEAN: begin
            tsum_in  = (cut_ff != '0) ? sum_ff - lo_sum_ff - hi_sum_ff : sum_ff;
            state_in = S_DIV_GO;
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               res_in   = div_quot[OW-1:0];
               state_in = S_EMIT;
            end
         end
         S_FINAL: begin
            if (mode_ff == tds_pkg::MODE_PCT) begin
               pmul_in  = 26'(vb_ff - va_ff) * 26'(frac_ff);
               state_in = S_PCT;
            end else begin
               res_in   = OW'({1'b0, va_ff} + {1'b0, vb_ff}) << 3;
               state_in = S_EMIT;
            end
         end
         S_PCT: begin
            res_in   = (OW'(va_ff) << 4) + OW'((pmul_ff + 26'd32) >> 6);
            state_in = S_EMIT;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_depth_in  = res_ff;
               rsp_status_in = rstat_ff;
               rsp_count_in  = tds_pkg::COUNT_W'(count_ff);
               count_in      = '0;
               sum_in        = '0;
               ovf_in        = 1'b0;
               state_in      = S_COLLECT;
            end
         end
         default: state_in = S_COLLECT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_COLLECT;
         count_ff     <= '0;
         sum_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         dv_ff        <= 1'b0;
         dl_ff        <= 1'b0;
         min_depth_ff <= 16'd100;
         max_depth_ff <= 16'd10000;
         mode_ff      <= tds_pkg::MODE_MEDIAN;
         pct_ff       <= 11'd512;
         ratio_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         dv_ff        <= dv_in;
         dl_ff        <= dl_in;
         if (csr_we) begin
            case (csr_index)
               tds_pkg::CSR_MIN_DEPTH:   min_depth_ff <= csr_wdata;
               tds_pkg::CSR_MAX_DEPTH:   max_depth_ff <= csr_wdata;
               tds_pkg::CSR_REDUCE_MODE: mode_ff <= csr_wdata[tds_pkg::MODE_W-1:0];
               tds_pkg::CSR_PERCENTILE:  pct_ff <= csr_wdata[tds_pkg::PCT_W-1:0];
               tds_pkg::CSR_TRIM_RATIO:  ratio_ff <= csr_wdata[tds_pkg::PCT_W-1:0];
               default: ;
            endcase
         end
      end
      prod_ff       <= prod_in;
      cut_ff        <= cut_in;
      m_ff          <= m_in;
      q_ff          <= q_in;
      frac_ff       <= frac_in;
      ra_ff         <= ra_in;
      rb_ff         <= rb_in;
      va_ff         <= va_in;
      vb_ff         <= vb_in;
      bit_ff        <= bit_in;
      sum_pass_ff   <= sum_pass_in;
      rd_cnt_ff     <= rd_cnt_in;
      cnt_a_ff      <= cnt_a_in;
      cnt_b_ff      <= cnt_b_in;
      lo_sum_ff     <= lo_sum_in;
      hi_sum_ff     <= hi_sum_in;
      tsum_ff       <= tsum_in;
      pmul_ff       <= pmul_in;
      res_ff        <= res_in;
      rstat_ff      <= rstat_in;
      rsp_depth_ff  <= rsp_depth_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // sample memory: one write port while collecting, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[count_ff[AW-1:0]] <= req_depth_mm;
      end
      mem_q_ff <= mem[rd_addr];
   end

   assign req_stall        = (state_ff != S_COLLECT);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_depth_out    = rsp_depth_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_sample_count = rsp_count_ff;

endmodule
